// File: rtl/ipm_pkg.sv
// Shared types, constants and the arctangent table for the remap index generator.
// No dependencies.
`default_nettype none
package ipm_pkg;

  localparam int unsigned MAX_SRC_DIM_DEF  = 2048;
  localparam int unsigned MAX_DST_DIM_DEF  = 512;
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  localparam int unsigned DP_W   = 34;
  localparam int unsigned ANG_W  = 24;
  localparam int unsigned IN_SH  = 16;

  localparam int unsigned SW_W   = 12;
  localparam int unsigned VP_W   = 11;
  localparam int unsigned DW_W   = 10;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned OUT_W  = 22;
  localparam int unsigned CIDX_W = 3;

  localparam logic [CIDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_VANISH_X   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_VANISH_Y   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_DST_WIDTH  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DST_HEIGHT = 3'd5;

  localparam longint AH_Q     = 732044;
  localparam longint AV_Q     = 457527;
  localparam longint TILT_Y0  = 60 * 107922;
  localparam longint DH       = 2 * AH_Q;
  localparam longint DV       = 2 * AV_Q;
  localparam int unsigned RECIP_SH = 44;
  localparam int unsigned RECIP_W  = 25;
  localparam logic [RECIP_W-1:0] MH = RECIP_W'((64'd1 << RECIP_SH) / DH);
  localparam logic [RECIP_W-1:0] MV = RECIP_W'((64'd1 << RECIP_SH) / DV);

  // lane widths
  localparam int unsigned T_W   = 22;
  localparam int unsigned MAG_W = 33;
  localparam int unsigned Q_W   = 12;
  localparam int unsigned D_W   = 21;

  // offset divider
  localparam int unsigned DIVN_W = 32;
  localparam int unsigned DEN_W  = 11;
  localparam int unsigned GOFF_W = 32;

  typedef struct packed {
    logic signed [DP_W-1:0]  x;
    logic signed [DP_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q20(input int unsigned i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0: r = ANG_W'(823549);
      1: r = ANG_W'(486169);
      2: r = ANG_W'(256878);
      3: r = ANG_W'(130395);
      4: r = ANG_W'(65450);
      5: r = ANG_W'(32757);
      6: r = ANG_W'(16382);
      7: r = ANG_W'(8191);
      8: r = ANG_W'(4095);
      9: r = ANG_W'(2047);
      10: r = ANG_W'(1023);
      11: r = ANG_W'(511);
      12: r = ANG_W'(255);
      13: r = ANG_W'(127);
      14: r = ANG_W'(63);
      15: r = ANG_W'(31);
      16: r = ANG_W'(15);
      17: r = ANG_W'(7);
      18: r = ANG_W'(3);
      19: r = ANG_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ipm_cordic_cell.sv
// One vectoring CORDIC iteration with a registered output.
// Depends on ipm_pkg.
`default_nettype none
module ipm_cordic_cell #(
  parameter int unsigned STEP  = 0,
  parameter int unsigned TAG_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  ipm_pkg::cordic_t       data_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   valid_o,
  output ipm_pkg::cordic_t       data_o,
  output logic [TAG_W-1:0]       tag_o
);

  logic signed [ipm_pkg::DP_W-1:0]  xs, ys;
  logic signed [ipm_pkg::ANG_W-1:0] ang;
  ipm_pkg::cordic_t                 data_d, data_q;
  logic                             valid_q;
  logic [TAG_W-1:0]                 tag_q;

  always_comb begin
    xs  = data_i.x >>> STEP;
    ys  = data_i.y >>> STEP;
    ang = ipm_pkg::atan_q20(STEP);
    if (!data_i.y[ipm_pkg::DP_W-1]) begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + ang;
    end else begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tag_q  <= tag_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign tag_o   = tag_q;

endmodule
`default_nettype wire

// File: rtl/ipm_cordic_chain.sv
// Row of CORDIC cells, one per iteration, each handing its item to the next.
// Depends on ipm_pkg and ipm_cordic_cell.
`default_nettype none
module ipm_cordic_chain #(
  parameter int unsigned STEPS = ipm_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned TAG_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  ipm_pkg::cordic_t       data_i,
  input  wire logic [TAG_W-1:0]  tag_i,
  output logic                   valid_o,
  output ipm_pkg::cordic_t       data_o,
  output logic [TAG_W-1:0]       tag_o
);

  logic             vld [STEPS+1];
  ipm_pkg::cordic_t dat [STEPS+1];
  logic [TAG_W-1:0] tag [STEPS+1];

  assign vld[0] = valid_i;
  assign dat[0] = data_i;
  assign tag[0] = tag_i;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ipm_cordic_cell #(
      .STEP  (i),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[i]),
      .data_i  (dat[i]),
      .tag_i   (tag[i]),
      .valid_o (vld[i+1]),
      .data_o  (dat[i+1]),
      .tag_o   (tag[i+1])
    );
  end

  assign valid_o = vld[STEPS];
  assign data_o  = dat[STEPS];
  assign tag_o   = tag[STEPS];

endmodule
`default_nettype wire

// File: rtl/ipm_offset_div.sv
// Radix-2 restoring divider, two quotient bits per cycle, for the pan/tilt offsets.
// Depends on ipm_pkg.
`default_nettype none
module ipm_offset_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [ipm_pkg::DIVN_W-1:0]        num_i,
  input  wire logic                              neg_i,
  input  wire logic [ipm_pkg::DEN_W-1:0]         den_i,
  output logic                                   busy_o,
  output logic signed [ipm_pkg::GOFF_W-1:0]      res_o
);

  localparam int unsigned CYC   = ipm_pkg::DIVN_W / 2;
  localparam int unsigned CNT_W = $clog2(CYC);

  logic [ipm_pkg::DIVN_W-1:0]       dq_q, dq_d;
  logic [ipm_pkg::DEN_W:0]          rem_q, rem_d;
  logic [ipm_pkg::DEN_W-1:0]        den_q;
  logic                             neg_q, busy_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic signed [ipm_pkg::GOFF_W-1:0] res_q;

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    for (int k = 0; k < 2; k++) begin
      rem_d = {rem_d[ipm_pkg::DEN_W-1:0], dq_d[ipm_pkg::DIVN_W-1]};
      dq_d  = {dq_d[ipm_pkg::DIVN_W-2:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d    = rem_d - {1'b0, den_q};
        dq_d[0]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      res_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(CYC - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        res_q  <= neg_q ? -$signed(dq_d) : $signed(dq_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// File: rtl/ipm_scale_lane.sv
// Angle to pixel coordinate: range check, scale by image size, divide by the field of view.
// Depends on ipm_pkg. Four register stages.
`default_nettype none
module ipm_scale_lane #(
  parameter longint DIV               = ipm_pkg::DH,
  parameter logic [ipm_pkg::RECIP_W-1:0] RECIP = ipm_pkg::MH
) (
  input  wire logic                            clk_i,
  input  wire logic signed [ipm_pkg::DP_W-1:0] t_i,
  input  wire logic [ipm_pkg::SW_W-1:0]        dim_i,
  output logic [ipm_pkg::Q_W-1:0]              q_o,
  output logic                                 neg_o,
  output logic                                 oor_o
);

  localparam logic signed [ipm_pkg::DP_W-1:0] DIV_S = ipm_pkg::DP_W'(DIV);
  localparam logic [ipm_pkg::D_W-1:0]         DIV_U = ipm_pkg::D_W'(DIV);

  localparam int unsigned P_W = ipm_pkg::T_W + ipm_pkg::SW_W + 1;
  localparam int unsigned R_W = ipm_pkg::MAG_W + ipm_pkg::RECIP_W;
  localparam int unsigned QD_W = ipm_pkg::Q_W + ipm_pkg::D_W;

  logic signed [ipm_pkg::T_W-1:0] t1_q;
  logic                           oor1_q, oor2_q, oor3_q, oor4_q;
  logic signed [P_W-1:0]          p2;
  logic [ipm_pkg::MAG_W-1:0]      mag2_q, mag3_q;
  logic                           neg2_q, neg3_q, neg4_q;
  logic [R_W-1:0]                 r3;
  logic [ipm_pkg::Q_W-1:0]        q03_q, q4_q;
  logic [QD_W-1:0]                qd4;
  logic [ipm_pkg::MAG_W-1:0]      rem4;

  assign p2   = t1_q * $signed({1'b0, dim_i});
  assign r3   = mag2_q * RECIP;
  assign qd4  = q03_q * DIV_U;
  assign rem4 = mag3_q - qd4[ipm_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i) begin
    t1_q   <= t_i[ipm_pkg::T_W-1:0];
    oor1_q <= (t_i >= DIV_S) || (t_i <= -DIV_S);

    neg2_q <= p2[P_W-1];
    mag2_q <= p2[P_W-1] ? ipm_pkg::MAG_W'(-p2) : ipm_pkg::MAG_W'(p2);
    oor2_q <= oor1_q;

    q03_q  <= r3[ipm_pkg::RECIP_SH +: ipm_pkg::Q_W];
    mag3_q <= mag2_q;
    neg3_q <= neg2_q;
    oor3_q <= oor2_q;

    q4_q   <= q03_q + ipm_pkg::Q_W'(rem4 >= ipm_pkg::MAG_W'(DIV_U));
    neg4_q <= neg3_q;
    oor4_q <= oor3_q;
  end

  assign q_o   = q4_q;
  assign neg_o = neg4_q;
  assign oor_o = oor4_q;

endmodule
`default_nettype wire

// File: rtl/ipm_remap_index_generator.sv
// Top level of the remap index generator: config registers, input stage, two CORDIC rows,
// offset dividers and the scaling lanes. Depends on ipm_pkg and the ipm_* rtl modules.
//
// Usage: drive lateral_index_i/forward_offset_i and pulse start_i; an item is taken at
// each rising edge with start_i high and busy_o low. One result appears per item on
// source_index_o/out_of_view_o, marked by valid_o for exactly one cycle; results cannot
// be held off and come out in order.
// Pipeline: one input stage, one cell per CORDIC iteration for pan and again for tilt,
// four scaling stages, the output register. Throughput: one item per cycle while busy_o
// is low; the datapath is a fully pipelined row of cells.
// Configuration: cfg_we_i/cfg_idx_i/cfg_wdata_i write one register per cycle; the user
// must write only while idle, which the block itself does not enforce. Any write restarts
// the pan/tilt offset dividers, which hold busy_o high from the launch until both are done.
// Reset: registers take their defaults (720x360 source, vanishing point 360,180, 200x200
// map); the offsets start at zero, which matches those defaults, so items are taken
// right after reset. Items in flight at reset are dropped.
`default_nettype none
module ipm_remap_index_generator #(
  parameter int unsigned MAX_SRC_DIM  = ipm_pkg::MAX_SRC_DIM_DEF,
  parameter int unsigned MAX_DST_DIM  = ipm_pkg::MAX_DST_DIM_DEF,
  parameter int unsigned CORDIC_STEPS = ipm_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic [ipm_pkg::IDX_W-1:0]   lateral_index_i,
  input  wire logic [ipm_pkg::IDX_W-1:0]   forward_offset_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [ipm_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  wire logic [ipm_pkg::SW_W-1:0]    cfg_wdata_i,
  output logic                             valid_o,
  output logic [ipm_pkg::OUT_W-1:0]        source_index_o,
  output logic                             out_of_view_o
);

  localparam int unsigned TAG_W = ipm_pkg::ANG_W + 1;
  localparam int unsigned LANE_LAT = 4;

  // configuration
  logic [ipm_pkg::SW_W-1:0] src_width_q, src_height_q;
  logic [ipm_pkg::VP_W-1:0] vanish_x_q, vanish_y_q;
  logic [ipm_pkg::DW_W-1:0] dst_width_q, dst_height_q;
  logic                     launch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= ipm_pkg::SW_W'(720);
      src_height_q <= ipm_pkg::SW_W'(360);
      vanish_x_q   <= ipm_pkg::VP_W'(360);
      vanish_y_q   <= ipm_pkg::VP_W'(180);
      dst_width_q  <= ipm_pkg::DW_W'(200);
      dst_height_q <= ipm_pkg::DW_W'(200);
      launch_q     <= 1'b0;
    end else begin
      launch_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ipm_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_wdata_i;
          ipm_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_wdata_i;
          ipm_pkg::REG_VANISH_X:   vanish_x_q   <= cfg_wdata_i[ipm_pkg::VP_W-1:0];
          ipm_pkg::REG_VANISH_Y:   vanish_y_q   <= cfg_wdata_i[ipm_pkg::VP_W-1:0];
          ipm_pkg::REG_DST_WIDTH:  dst_width_q  <= cfg_wdata_i[ipm_pkg::DW_W-1:0];
          ipm_pkg::REG_DST_HEIGHT: dst_height_q <= cfg_wdata_i[ipm_pkg::DW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // pan/tilt offsets from the vanishing point
  logic [ipm_pkg::DEN_W-1:0]        hw, hh;
  logic signed [ipm_pkg::SW_W:0]    gdiff, tdiff;
  logic signed [ipm_pkg::DIVN_W:0]  gprod, tprod;
  logic                             gdiv_busy, tdiv_busy;
  logic signed [ipm_pkg::GOFF_W-1:0] gamma, theta;

  assign hw    = src_width_q[ipm_pkg::SW_W-1:1];
  assign hh    = src_height_q[ipm_pkg::SW_W-1:1];
  assign gdiff = $signed({2'b0, vanish_x_q}) - $signed({2'b0, hw});
  assign tdiff = $signed({2'b0, vanish_y_q}) - $signed({2'b0, hh});
  assign gprod = gdiff * $signed(21'(ipm_pkg::AH_Q));
  assign tprod = tdiff * $signed(21'(ipm_pkg::AV_Q));

  ipm_offset_div u_gdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (launch_q),
    .num_i   (gprod[ipm_pkg::DIVN_W] ? ipm_pkg::DIVN_W'(-gprod) : ipm_pkg::DIVN_W'(gprod)),
    .neg_i   (!gprod[ipm_pkg::DIVN_W]),
    .den_i   (hw),
    .busy_o  (gdiv_busy),
    .res_o   (gamma)
  );

  ipm_offset_div u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (launch_q),
    .num_i   (tprod[ipm_pkg::DIVN_W] ? ipm_pkg::DIVN_W'(-tprod) : ipm_pkg::DIVN_W'(tprod)),
    .neg_i   (!tprod[ipm_pkg::DIVN_W]),
    .den_i   (hh),
    .busy_o  (tdiv_busy),
    .res_o   (theta)
  );

  assign busy_o = launch_q | gdiv_busy | tdiv_busy;

  // input stage
  logic                             accept;
  logic signed [ipm_pkg::IDX_W+1:0] fdiff, ldiff;
  logic signed [ipm_pkg::IDX_W+3:0] dx;
  logic signed [ipm_pkg::IDX_W+2:0] dy, dy_use;
  logic                             dy_zero, cfg_bad, bad_in;
  logic                             s0_valid_q, s0_bad_q;
  ipm_pkg::cordic_t                 s0_q;

  assign accept  = start_i && !busy_o;
  assign fdiff   = $signed({1'b0, dst_height_q}) - $signed({2'b0, forward_offset_i});
  assign ldiff   = $signed({2'b0, lateral_index_i}) - $signed({2'b0, dst_width_q[ipm_pkg::DW_W-1:1]});
  assign dx      = {fdiff, 2'b00};
  assign dy      = {ldiff, 1'b0};
  assign dy_zero = (dy == '0);
  assign dy_use  = dy_zero ? -(ipm_pkg::IDX_W+3)'(2) : dy;
  assign cfg_bad = (src_width_q < ipm_pkg::SW_W'(2)) || (32'(src_width_q) > MAX_SRC_DIM) ||
                   (src_height_q < ipm_pkg::SW_W'(2)) || (32'(src_height_q) > MAX_SRC_DIM) ||
                   (32'(dst_width_q) > MAX_DST_DIM) || (32'(dst_height_q) > MAX_DST_DIM);
  assign bad_in  = cfg_bad || (dx <= 0) || (dy_zero && (lateral_index_i == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_bad_q <= bad_in;
    s0_q.x   <= ipm_pkg::DP_W'(dx) <<< ipm_pkg::IN_SH;
    s0_q.y   <= ipm_pkg::DP_W'(dy_use) <<< ipm_pkg::IN_SH;
    s0_q.z   <= '0;
  end

  // pan row
  logic             pan_valid;
  ipm_pkg::cordic_t pan_data;
  logic [0:0]       pan_tag;

  ipm_cordic_chain #(
    .STEPS (CORDIC_STEPS),
    .TAG_W (1)
  ) u_pan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .data_i  (s0_q),
    .tag_i   (s0_bad_q),
    .valid_o (pan_valid),
    .data_o  (pan_data),
    .tag_o   (pan_tag)
  );

  // tilt row
  ipm_pkg::cordic_t tilt_in, tilt_data;
  logic             tilt_valid;
  logic [TAG_W-1:0] tilt_tag;

  always_comb begin
    tilt_in.x = pan_data.x;
    tilt_in.y = ipm_pkg::DP_W'(ipm_pkg::TILT_Y0);
    tilt_in.z = '0;
  end

  ipm_cordic_chain #(
    .STEPS (CORDIC_STEPS),
    .TAG_W (TAG_W)
  ) u_tilt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pan_valid),
    .data_i  (tilt_in),
    .tag_i   ({pan_data.z, pan_tag}),
    .valid_o (tilt_valid),
    .data_o  (tilt_data),
    .tag_o   (tilt_tag)
  );

  // scaling lanes
  logic signed [ipm_pkg::DP_W-1:0] tv, tu;
  logic [ipm_pkg::Q_W-1:0]         qv, qu;
  logic                            negv, negu, oorv, oru;

  assign tv = ipm_pkg::DP_W'($signed(tilt_tag[TAG_W-1:1])) - ipm_pkg::DP_W'(gamma) +
              ipm_pkg::DP_W'(ipm_pkg::AH_Q);
  assign tu = ipm_pkg::DP_W'(tilt_data.z) - ipm_pkg::DP_W'(theta) +
              ipm_pkg::DP_W'(ipm_pkg::AV_Q);

  ipm_scale_lane #(
    .DIV   (ipm_pkg::DH),
    .RECIP (ipm_pkg::MH)
  ) u_lane_v (
    .clk_i (clk_i),
    .t_i   (tv),
    .dim_i (src_width_q),
    .q_o   (qv),
    .neg_o (negv),
    .oor_o (oorv)
  );

  ipm_scale_lane #(
    .DIV   (ipm_pkg::DV),
    .RECIP (ipm_pkg::MV)
  ) u_lane_u (
    .clk_i (clk_i),
    .t_i   (tu),
    .dim_i (src_height_q),
    .q_o   (qu),
    .neg_o (negu),
    .oor_o (oru)
  );

  logic [LANE_LAT-1:0] lv_q, lb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
    end else begin
      lv_q <= {lv_q[LANE_LAT-2:0], tilt_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    lb_q <= {lb_q[LANE_LAT-2:0], tilt_tag[0]};
  end

  // output register
  logic                        v_ok, u_ok, in_view;
  logic [2*ipm_pkg::SW_W-1:0]  row_base;
  logic [ipm_pkg::OUT_W-1:0]   index_d, index_q;
  logic                        valid_q, oov_q;

  assign v_ok     = !oorv && (negv ? (qv == '0) : (qv < src_width_q));
  assign u_ok     = !oru && (negu ? (qu == '0) : (qu < src_height_q));
  assign in_view  = !lb_q[LANE_LAT-1] && v_ok && u_ok;
  assign row_base = src_width_q * qu;
  assign index_d  = in_view ? ipm_pkg::OUT_W'(row_base + {{ipm_pkg::SW_W{1'b0}}, qv}) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= lv_q[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= index_d;
    oov_q   <= !in_view;
  end

  assign valid_o        = valid_q;
  assign source_index_o = index_q;
  assign out_of_view_o  = oov_q;

endmodule
`default_nettype wire

// File: dv/ipm_remap_checker.sv
// Checker for the remap index generator: watches the item, config and result ports,
// predicts each source index and compares in order. Depends on ipm_pkg.
module ipm_remap_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [ipm_pkg::IDX_W-1:0]    lateral_index_i,
  input  logic [ipm_pkg::IDX_W-1:0]    forward_offset_i,
  input  logic                         cfg_we_i,
  input  logic [ipm_pkg::CIDX_W-1:0]   cfg_idx_i,
  input  logic [ipm_pkg::SW_W-1:0]     cfg_wdata_i,
  input  logic                         valid_i,
  input  logic [ipm_pkg::OUT_W-1:0]    source_index_i,
  input  logic                         out_of_view_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import ipm_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] source_index;
    logic             out_of_view;
  } remap_t;

  localparam longint ATAN_TAB [20] = '{823549, 486169, 256878, 130395, 65450, 32757,
    16382, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};

  remap_t expected_q[$];
  longint src_w, src_h, van_x, van_y, map_w, map_h;
  int fails;

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  function automatic void vector_angle(input longint x0, input longint y0,
                                       output longint ang, output longint mag);
    longint x, y, xs, ys;
    x = x0;
    y = y0;
    ang = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ang += (i < 20) ? ATAN_TAB[i] : 0;
      end else begin
        x -= ys; y += xs; ang -= (i < 20) ? ATAN_TAB[i] : 0;
      end
    end
    mag = x;
  endfunction

  function automatic remap_t predict_remap(input longint lat, input longint off);
    remap_t r;
    longint dx, dy, pan, tilt, mag, junk, hw, hh, gam, thet, u, v;
    r.source_index = '0;
    r.out_of_view = 1'b1;
    if (src_w < 2 || src_w > MAX_SRC_DIM_DEF || src_h < 2 || src_h > MAX_SRC_DIM_DEF ||
        map_w > MAX_DST_DIM_DEF || map_h > MAX_DST_DIM_DEF)
      return r;
    dx = 4 * (map_h - off);
    if (dx <= 0) return r;
    dy = 2 * (lat - (map_w >> 1));
    if (dy == 0) begin
      if (lat == 0) return r;
      dy = -2;
    end
    vector_angle(dx <<< IN_SH, dy <<< IN_SH, pan, mag);
    vector_angle(mag, TILT_Y0, tilt, junk);
    hw = src_w >> 1;
    hh = src_h >> 1;
    gam = -((van_x - hw) * AH_Q) / hw;
    thet = -((van_y - hh) * AV_Q) / hh;
    v = (pan - gam + AH_Q) * src_w / DH;
    u = (tilt - thet + AV_Q) * src_h / DV;
    if (u >= 0 && u < src_h && v >= 0 && v < src_w) begin
      r.source_index = OUT_W'(src_w * u + v);
      r.out_of_view = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    remap_t exp_r;
    if (!rst_ni) begin
      src_w = 720; src_h = 360; van_x = 360; van_y = 180; map_w = 200; map_h = 200;
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SRC_WIDTH:  src_w = cfg_wdata_i;
          REG_SRC_HEIGHT: src_h = cfg_wdata_i;
          REG_VANISH_X:   van_x = cfg_wdata_i[VP_W-1:0];
          REG_VANISH_Y:   van_y = cfg_wdata_i[VP_W-1:0];
          REG_DST_WIDTH:  map_w = cfg_wdata_i[DW_W-1:0];
          REG_DST_HEIGHT: map_h = cfg_wdata_i[DW_W-1:0];
          default: ;
        endcase
      end
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: source_index %0d out_of_view %0b",
                 source_index_i, out_of_view_i);
          fails++;
        end else begin
          exp_r = expected_q.pop_front();
          if (source_index_i !== exp_r.source_index) begin
            $error("source_index: expected %0d actual %0d", exp_r.source_index,
                   source_index_i);
            fails++;
          end
          if (out_of_view_i !== exp_r.out_of_view) begin
            $error("out_of_view: expected %0b actual %0b", exp_r.out_of_view,
                   out_of_view_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i)
        expected_q.push_back(predict_remap(lateral_index_i, forward_offset_i));
    end
  end
endmodule

// File: dv/testbench.sv
// Top of the remap index generator testbench: clock, reset, config phases and item
// stimulus with random gaps. Depends on ipm_pkg, ipm_remap_index_generator, ipm_remap_checker.
module testbench;
  import ipm_pkg::*;

  localparam int LIMIT = 400000;
  localparam int NUM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS_DEF + 12;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [IDX_W-1:0]  lateral_index_i = '0;
  logic [IDX_W-1:0]  forward_offset_i = '0;
  logic              cfg_we_i = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i = REG_SRC_WIDTH;
  logic [SW_W-1:0]   cfg_wdata_i = '0;
  logic              busy_o, valid_o, out_of_view_o;
  logic [OUT_W-1:0]  source_index_o;
  int                fail_count, pending;
  int                cycles = 0;
  int                gap_pct;
  int                map_w, map_h;

  ipm_remap_index_generator dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .lateral_index_i, .forward_offset_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .valid_o, .source_index_o, .out_of_view_o
  );

  ipm_remap_checker checker_u (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .lateral_index_i, .forward_offset_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .valid_i(valid_o), .source_index_i(source_index_o),
    .out_of_view_i(out_of_view_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("ipm_remap_index_generator test failed");
      $finish;
    end
  end

  // each cycle before an item is idle with probability gap_pct percent
  task automatic send_item(input int lat, input int off);
    logic b;
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    lateral_index_i <= IDX_W'(lat);
    forward_offset_i <= IDX_W'(off);
    start_i <= 1'b1;
    forever begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
      if (!b) break;
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input int sw, input int sh, input int vx, input int vy,
                              input int dw, input int dh);
    logic [SW_W-1:0] vals [6];
    logic [CIDX_W-1:0] idxs [6];
    vals = '{SW_W'(sw), SW_W'(sh), SW_W'(vx), SW_W'(vy), SW_W'(dw), SW_W'(dh)};
    idxs = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_VANISH_X, REG_VANISH_Y,
             REG_DST_WIDTH, REG_DST_HEIGHT};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idxs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    map_w = dw & 10'h3ff;
    map_h = dh & 10'h3ff;
  endtask

  initial begin
    int lat, off;
    int dir_lat [15] = '{0, 511, 100, 100, 99, 101, 0, 199, 511, 0, 200, 150, 150, 255, 256};
    int dir_off [15] = '{0, 511, 0, 199, 0, 199, 199, 0, 0, 511, 5, 200, 300, 256, 255};
    map_w = 200;
    map_h = 200;
    gap_pct = 25;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NUM_PHASES; p++) begin
      gap_pct = (p < 3) ? 25 : (p < 6) ? 80 : 0;
      case (p)
        0: for (int i = 0; i < 15; i++) send_item(dir_lat[i], dir_off[i]);
        1: write_config(2048, 2048, 0, 2047, 512, 512);
        2: write_config(2, 2, 0, 0, 2, 1);
        3: write_config(720, 360, 360, 180, 1, 200);
        4: write_config(4095, 0, 2047, 2047, 1023, 1023);
        default: write_config($urandom_range(2, 2048), $urandom_range(2, 2048),
                              $urandom_range(0, 2047), $urandom_range(0, 2047),
                              $urandom_range(2, 512), $urandom_range(1, 512));
      endcase
      send_item(0, 0);
      send_item(map_w >> 1, 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 85 && map_w >= 1 && map_w <= 512 && map_h >= 1 &&
            map_h <= 512) begin
          lat = $urandom_range(0, map_w - 1);
          off = $urandom_range(0, map_h - 1);
        end else begin
          lat = $urandom_range(0, 511);
          off = $urandom_range(0, 511);
        end
        send_item(lat, off);
      end
      drain();
    end
    if (fail_count == 0 && pending == 0)
      $display("ipm_remap_index_generator test passed");
    else
      $display("ipm_remap_index_generator test failed");
    $finish;
  end
endmodule
